>>> hdl/perf_monitor_counter_unit_defines.svh
// Assertion macros for the performance monitor counter unit.
// Included by modules that carry concurrent checks; needs no other file.
`ifndef PERF_MONITOR_COUNTER_UNIT_DEFINES_SVH
`define PERF_MONITOR_COUNTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PMCU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PMCU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/pmcu_pkg.sv
// Shared constants for the performance monitor counter unit.
// Used by the channel interfaces and the top level; depends on nothing.
package pmcu_pkg;

  localparam int NUM_COUNTERS = 4;
  localparam int IDX_W = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;

  localparam int DATA_W = 32;
  localparam int REQ_W = 2;
  localparam int ADDR_W = 4;
  localparam int SEL_W = 5;
  localparam int EVT_W = 8;
  localparam int PRE_W = 6;
  localparam int CTRL_W = 3;

  localparam logic [REQ_W-1:0] REQ_NONE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd2;

  localparam logic [ADDR_W-1:0] ADDR_CONTROL = 4'd0;
  localparam logic [ADDR_W-1:0] ADDR_ENSET   = 4'd1;
  localparam logic [ADDR_W-1:0] ADDR_ENCLR   = 4'd2;
  localparam logic [ADDR_W-1:0] ADDR_OVF     = 4'd3;
  localparam logic [ADDR_W-1:0] ADDR_SELECT  = 4'd4;
  localparam logic [ADDR_W-1:0] ADDR_CYCLE   = 4'd5;
  localparam logic [ADDR_W-1:0] ADDR_EVTYPE  = 4'd6;
  localparam logic [ADDR_W-1:0] ADDR_EVCOUNT = 4'd7;
  localparam logic [ADDR_W-1:0] ADDR_INTSET  = 4'd8;
  localparam logic [ADDR_W-1:0] ADDR_INTCLR  = 4'd9;

  // Stored control bit positions.
  localparam int CTRL_EN  = 0;
  localparam int CTRL_DIV = 1;
  localparam int CTRL_EXP = 2;

  // Control register write and read bit positions.
  localparam int WR_EN      = 0;
  localparam int WR_EV_RST  = 1;
  localparam int WR_CYC_RST = 2;
  localparam int WR_DIV     = 3;
  localparam int WR_EXP     = 4;

  localparam int CYC_POS = DATA_W - 1;

  localparam logic [DATA_W-1:0] EV_MASK =
    DATA_W'((64'd1 << NUM_COUNTERS) - 64'd1);
  localparam logic [DATA_W-1:0] CYC_MASK = DATA_W'(64'd1 << CYC_POS);
  localparam logic [DATA_W-1:0] VALID_MASK = EV_MASK | CYC_MASK;

endpackage

>>> hdl/pmcu_req_if.sv
// Request channel of the performance monitor counter unit.
// Carries one core cycle: optional register access plus event pulses; uses pmcu_pkg.
interface pmcu_req_if;
  logic                          valid;
  logic                          ready;
  logic [pmcu_pkg::REQ_W-1:0]    req_type;
  logic [pmcu_pkg::ADDR_W-1:0]   reg_addr;
  logic [pmcu_pkg::DATA_W-1:0]   write_data;
  logic [pmcu_pkg::DATA_W-1:0]   event_pulses;

  modport source (output valid, req_type, reg_addr, write_data, event_pulses, input ready);
  modport sink   (input valid, req_type, reg_addr, write_data, event_pulses, output ready);
endinterface

>>> hdl/pmcu_rsp_if.sv
// Response channel of the performance monitor counter unit.
// Carries read data and the interrupt level; uses pmcu_pkg.
interface pmcu_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pmcu_pkg::DATA_W-1:0]   read_data;
  logic                          irq;

  modport source (output valid, read_data, irq, input ready);
  modport sink   (input valid, read_data, irq, output ready);
endinterface

>>> hdl/perf_monitor_counter_unit.sv
// Performance monitor counter unit: takes one request per cycle unless stalled and
// returns one response for each. A request enters an input register; the register
// update and read mux sit in one pass of logic from there to the response
// register, so a new request is taken every cycle unless the response register
// is full and stalled. Depends on pmcu_pkg, pmcu_req_if, pmcu_rsp_if and the
// assertion macros header.
`include "perf_monitor_counter_unit_defines.svh"

module perf_monitor_counter_unit (
  input  logic       clk,
  input  logic       rst,
  pmcu_req_if.sink   req,
  pmcu_rsp_if.source rsp
);

  localparam int N  = pmcu_pkg::NUM_COUNTERS;
  localparam int DW = pmcu_pkg::DATA_W;

  // Input register.
  logic                           s_valid;
  logic [pmcu_pkg::REQ_W-1:0]     s_req_type;
  logic [pmcu_pkg::ADDR_W-1:0]    s_reg_addr;
  logic [DW-1:0]                  s_write_data;
  logic [DW-1:0]                  s_event_pulses;

  // Response register.
  logic                           o_valid;
  logic [DW-1:0]                  o_read_data;
  logic                           o_irq;

  // Architectural state.
  logic [pmcu_pkg::CTRL_W-1:0]    ctrl;
  logic [DW-1:0]                  cen;
  logic [DW-1:0]                  ien;
  logic [DW-1:0]                  ovf;
  logic [pmcu_pkg::SEL_W-1:0]     sel;
  logic [N-1:0][pmcu_pkg::EVT_W-1:0] etype;
  logic [N-1:0][DW-1:0]           ecount;
  logic [DW-1:0]                  cyc;
  logic [pmcu_pkg::PRE_W-1:0]     pre;

  logic [pmcu_pkg::CTRL_W-1:0]    ctrl_next;
  logic [DW-1:0]                  cen_next;
  logic [DW-1:0]                  ien_next;
  logic [DW-1:0]                  ovf_next;
  logic [pmcu_pkg::SEL_W-1:0]     sel_next;
  logic [N-1:0][pmcu_pkg::EVT_W-1:0] etype_next;
  logic [N-1:0][DW-1:0]           ecount_next;
  logic [DW-1:0]                  cyc_next;
  logic [pmcu_pkg::PRE_W-1:0]     pre_next;

  logic                           advance;
  logic                           sel_ok;
  logic [pmcu_pkg::IDX_W-1:0]     sel_idx;
  logic [DW-1:0]                  rdata;
  logic [N-1:0]                   held_ev;
  logic                           held_cyc;
  logic [DW-1:0]                  newflags;
  logic [DW-1:0]                  ovf_w;
  logic                           tick;
  logic                           is_read;
  logic                           is_write;

  assign advance   = s_valid && (!o_valid || rsp.ready);
  assign req.ready = !s_valid || advance;
  assign rsp.valid     = o_valid;
  assign rsp.read_data = o_read_data;
  assign rsp.irq       = o_irq;

  assign sel_ok   = sel < pmcu_pkg::SEL_W'(N);
  assign sel_idx  = sel[pmcu_pkg::IDX_W-1:0];
  assign is_read  = s_req_type == pmcu_pkg::REQ_READ;
  assign is_write = s_req_type == pmcu_pkg::REQ_WRITE;

  always_comb begin
    rdata = '0;
    if (is_read) begin
      unique case (s_reg_addr)
        pmcu_pkg::ADDR_CONTROL: rdata = {16'b0, 5'(N), 6'b0, ctrl[pmcu_pkg::CTRL_EXP],
                                         ctrl[pmcu_pkg::CTRL_DIV], 2'b0,
                                         ctrl[pmcu_pkg::CTRL_EN]};
        pmcu_pkg::ADDR_ENSET,
        pmcu_pkg::ADDR_ENCLR:   rdata = cen;
        pmcu_pkg::ADDR_OVF:     rdata = ovf;
        pmcu_pkg::ADDR_SELECT:  rdata = DW'(sel);
        pmcu_pkg::ADDR_CYCLE:   rdata = cyc;
        pmcu_pkg::ADDR_EVTYPE:  rdata = sel_ok ? DW'(etype[sel_idx]) : '0;
        pmcu_pkg::ADDR_EVCOUNT: rdata = sel_ok ? ecount[sel_idx] : '0;
        pmcu_pkg::ADDR_INTSET,
        pmcu_pkg::ADDR_INTCLR:  rdata = ien;
        default:                rdata = '0;
      endcase
    end
  end

  always_comb begin
    ctrl_next   = ctrl;
    cen_next    = cen;
    ien_next    = ien;
    ovf_w       = ovf;
    sel_next    = sel;
    etype_next  = etype;
    ecount_next = ecount;
    cyc_next    = cyc;
    pre_next    = pre;
    held_ev     = '0;
    held_cyc    = 1'b0;
    newflags    = '0;
    tick        = 1'b0;

    if (is_write) begin
      unique case (s_reg_addr)
        pmcu_pkg::ADDR_CONTROL: begin
          ctrl_next = {s_write_data[pmcu_pkg::WR_EXP], s_write_data[pmcu_pkg::WR_DIV],
                       s_write_data[pmcu_pkg::WR_EN]};
          if (s_write_data[pmcu_pkg::WR_EV_RST]) begin
            ecount_next = '0;
            held_ev     = '1;
          end
          if (s_write_data[pmcu_pkg::WR_CYC_RST]) begin
            cyc_next = '0;
            pre_next = '0;
            held_cyc = 1'b1;
          end
        end
        pmcu_pkg::ADDR_ENSET:  cen_next = cen | (s_write_data & pmcu_pkg::VALID_MASK);
        pmcu_pkg::ADDR_ENCLR:  cen_next = cen & ~(s_write_data & pmcu_pkg::VALID_MASK);
        pmcu_pkg::ADDR_OVF:    ovf_w = ovf & ~(s_write_data & pmcu_pkg::VALID_MASK);
        pmcu_pkg::ADDR_SELECT: sel_next = s_write_data[pmcu_pkg::SEL_W-1:0];
        pmcu_pkg::ADDR_CYCLE: begin
          cyc_next = s_write_data;
          held_cyc = 1'b1;
        end
        pmcu_pkg::ADDR_EVTYPE: begin
          if (sel_ok) etype_next[sel_idx] = s_write_data[pmcu_pkg::EVT_W-1:0];
        end
        pmcu_pkg::ADDR_EVCOUNT: begin
          if (sel_ok) begin
            ecount_next[sel_idx] = s_write_data;
            held_ev[sel_idx]     = 1'b1;
          end
        end
        pmcu_pkg::ADDR_INTSET: ien_next = ien | (s_write_data & pmcu_pkg::VALID_MASK);
        pmcu_pkg::ADDR_INTCLR: ien_next = ien & ~(s_write_data & pmcu_pkg::VALID_MASK);
        default: ;
      endcase
    end

    if (ctrl_next[pmcu_pkg::CTRL_EN]) begin
      if (cen_next[pmcu_pkg::CYC_POS] && !held_cyc) begin
        tick = 1'b1;
        if (ctrl_next[pmcu_pkg::CTRL_DIV]) begin
          pre_next = pre + 1'b1;
          tick     = pre_next == '0;
        end
        if (tick) begin
          cyc_next = cyc + 1'b1;
          newflags[pmcu_pkg::CYC_POS] = &cyc;
        end
      end
      for (int i = 0; i < N; i++) begin
        if (cen_next[i] && !held_ev[i] && etype_next[i][7:5] == 3'b0 &&
            s_event_pulses[etype_next[i][4:0]]) begin
          ecount_next[i] = ecount[i] + 1'b1;
          newflags[i]    = &ecount[i];
        end
      end
    end

    ovf_next = ovf_w | newflags;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
    if (req.valid && req.ready) begin
      s_req_type     <= req.req_type;
      s_reg_addr     <= req.reg_addr;
      s_write_data   <= req.write_data;
      s_event_pulses <= req.event_pulses;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
    if (advance) begin
      o_read_data <= rdata;
      o_irq       <= |(ovf_next & ien_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl   <= '0;
      cen    <= '0;
      ien    <= '0;
      ovf    <= '0;
      sel    <= '0;
      etype  <= '0;
      ecount <= '0;
      cyc    <= '0;
      pre    <= '0;
    end else if (advance) begin
      ctrl   <= ctrl_next;
      cen    <= cen_next;
      ien    <= ien_next;
      ovf    <= ovf_next;
      sel    <= sel_next;
      etype  <= etype_next;
      ecount <= ecount_next;
      cyc    <= cyc_next;
      pre    <= pre_next;
    end
  end

  `PMCU_ASSERT_NEXT(a_irq_matches_state, clk, rst, advance, rsp.irq == |(ovf & ien), "irq does not match flags and mask")
  `PMCU_ASSERT_NEXT(a_read_zero_unless_read, clk, rst, advance && !is_read, rsp.read_data == '0, "read data nonzero without a read request")
  `PMCU_ASSERT_NOW(a_masks_in_range, clk, rst, 1'b1, ((cen | ien | ovf) & ~pmcu_pkg::VALID_MASK) == '0, "mask bit set outside implemented counters")
  `PMCU_ASSERT_NEXT(a_event_reset, clk, rst, advance && is_write && s_reg_addr == pmcu_pkg::ADDR_CONTROL && s_write_data[pmcu_pkg::WR_EV_RST], ecount == '0, "event counters not cleared by control reset")
  `PMCU_ASSERT_NOW(a_ready_when_free, clk, rst, !s_valid, req.ready, "request refused with empty input register")

endmodule
